### design/gnd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnd_pkg: shared types and constants of the Gaussian neighbour density unit
// Beat types, command codes, register indexes, widths and the weight table
// generator function.
// ----------------------------------------------------------------------------
package gnd_pkg;

  localparam int MAX_REFS_DEF  = 4096;
  localparam int EXP_DEPTH_DEF = 256;

  localparam int COORD_W  = 24;
  localparam int DENS_W   = 24;
  localparam int SIGMA_W  = 16;
  localparam int WEIGHT_W = 13;
  localparam int CMP_W    = 27;   // doubled coordinates and window bounds
  localparam int ABS_W    = 25;   // magnitude of a coordinate difference
  localparam int SQ_W     = 50;   // square of a difference
  localparam int DIVD_W   = 56;   // dividend of the exponent divisions
  localparam int DIVS_W   = 34;   // divisor: two sigma squared
  localparam int QUO_W    = 24;   // quotient in Q.20
  localparam int FRAC_E   = 20;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_QUERY = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic REG_LATERAL = 1'b0;
  localparam logic REG_AXIAL   = 1'b1;

  localparam logic [SIGMA_W-1:0] LATERAL_RESET = 16'd256;
  localparam logic [SIGMA_W-1:0] AXIAL_RESET   = 16'd512;

  typedef struct packed {
    logic [1:0]                command;
    logic signed [COORD_W-1:0] coord_x;
    logic signed [COORD_W-1:0] coord_y;
    logic signed [COORD_W-1:0] coord_z;
    logic                      last_query;
  } in_beat_t;

  typedef struct packed {
    logic [DENS_W-1:0] density;
    logic              saturated;
  } out_beat_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
  } ref_point_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SETUP, ST_READ, ST_EVAL, ST_SQUARE, ST_TEST,
    ST_DIVIDE, ST_SCALE, ST_INDEX, ST_LOOKUP, ST_ACCUM, ST_DONE
  } state_t;

  // Entry k of the weight table, exp(-10k/depth) in Q1.12. The step is
  // (10 << 32) / depth; the ratio m comes from a 20-term series in Q.32.
  function automatic logic [WEIGHT_W-1:0] exp_weight(int unsigned k, logic [63:0] step);
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] t;
    int unsigned n;
    int unsigned j;
    term = 64'd1 << 32;
    sum  = 64'd1 << 32;
    for (n = 1; n <= 20; n++) begin
      term = ((term * step) >> 32) / 64'(n);
      if (n[0]) begin
        sum = sum - term;
      end else begin
        sum = sum + term;
      end
    end
    t = 64'd1 << 32;
    for (j = 0; j < k; j++) begin
      t = (t * sum) >> 32;
    end
    return WEIGHT_W'((t + (64'd1 << 19)) >> 20);
  endfunction

endpackage

### design/gnd_ref_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnd_ref_mem: reference point store
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module gnd_ref_mem #(
  parameter int Depth = gnd_pkg::MAX_REFS_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  gnd_pkg::ref_point_t      wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output gnd_pkg::ref_point_t      rdata_r
);

  gnd_pkg::ref_point_t mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

endmodule

### design/gnd_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnd_div: restoring divider
// One quotient bit per cycle. The caller guarantees the quotient fits in
// QuoW bits, so the upper dividend bits start out below the divisor.
// ----------------------------------------------------------------------------
module gnd_div #(
  parameter int DvdW = gnd_pkg::DIVD_W,
  parameter int DvsW = gnd_pkg::DIVS_W,
  parameter int QuoW = gnd_pkg::QUO_W
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [DvdW-1:0] dividend,
  input  logic [DvsW-1:0] divisor,
  output logic            busy,
  output logic [QuoW-1:0] quotient
);

  localparam int CntW = $clog2(QuoW + 1);

  logic [DvsW-1:0] rem_r, rem_nxt;
  logic [DvsW-1:0] dvs_r;
  logic [QuoW-1:0] low_r, low_nxt;
  logic [CntW-1:0] cnt_r;
  logic [DvsW:0]   shifted;
  logic            ge;

  always_comb begin
    shifted = {rem_r, low_r[QuoW-1]};
    ge      = shifted >= {1'b0, dvs_r};
    rem_nxt = ge ? DvsW'(shifted - {1'b0, dvs_r}) : shifted[DvsW-1:0];
    low_nxt = {low_r[QuoW-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= CntW'(QuoW);
    end else if (cnt_r != '0) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= DvsW'(dividend[DvdW-1:QuoW]);
      low_r <= dividend[QuoW-1:0];
      dvs_r <= divisor;
    end else if (cnt_r != '0) begin
      rem_r <= rem_nxt;
      low_r <= low_nxt;
    end
  end

  assign busy     = cnt_r != '0;
  assign quotient = low_r;

endmodule

### design/gnd_weight_rom.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnd_weight_rom: Gaussian weight table
// Constant table of exp(-10k/Depth) in Q1.12 with a registered output.
// ----------------------------------------------------------------------------
module gnd_weight_rom #(
  parameter int Depth = gnd_pkg::EXP_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic [$clog2(Depth)-1:0]      idx,
  output logic [gnd_pkg::WEIGHT_W-1:0]  weight_r
);

  localparam logic [63:0] Step = (64'd10 << 32) / Depth;

  logic [gnd_pkg::WEIGHT_W-1:0] tbl [Depth];

  for (genvar k = 0; k < Depth; k++) begin : g_tbl
    assign tbl[k] = gnd_pkg::exp_weight(k, Step);
  end

  always_ff @(posedge clk) begin
    weight_r <= tbl[idx];
  end

endmodule

### design/gaussian_neighbour_density_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gaussian_neighbour_density_unit: Gaussian kernel density over a sorted window
// Loads reference points into a store, then answers queries with a saturating
// sum of Gaussian weights over the references near each query.
// ----------------------------------------------------------------------------
// A beat is taken when start is high and busy is low. Load, clear and unknown
// commands are accepted and keep busy low. A query raises busy and ends with
// exactly one result beat on out_beat, marked by out_valid for a single cycle;
// the result cannot be held off, so the receiver must take it in that cycle.
// The query cost is set by the single read port of the reference store and by
// the bit-serial dividers: a setup state; read and evaluate per reference
// visited while the window start moves forward or rejected by the x window;
// square and test as well per reference that reaches the y and z tests;
// divide (held while the dividers step), scale, index, lookup and accumulate
// as well per reference that adds a weight; a done state for the result beat.
// The reference store is not cleared after reset; only entries below the
// reference count are ever read. Configuration is written through the APB
// port; the user must do so only while busy is low; the block does not check.
// ----------------------------------------------------------------------------
module gaussian_neighbour_density_unit #(
  parameter int MaxRefs  = gnd_pkg::MAX_REFS_DEF,
  parameter int ExpDepth = gnd_pkg::EXP_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  gnd_pkg::in_beat_t  in_beat,
  output logic               out_valid,
  output gnd_pkg::out_beat_t out_beat,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int AW = $clog2(MaxRefs);
  localparam int IW = $clog2(ExpDepth);
  localparam int DepthW = $clog2(ExpDepth + 1);
  localparam int ProdW = gnd_pkg::QUO_W + 1 + DepthW;

  // Configuration registers.
  logic [gnd_pkg::SIGMA_W-1:0] lat_sigma_r, ax_sigma_r;
  logic                        cfg_write;

  // Control state.
  gnd_pkg::state_t state_r, state_nxt;
  logic [AW:0]     ref_count_r;
  logic [AW-1:0]   win_start_r;
  logic [AW-1:0]   ptr_r;
  logic            skip_r;

  // Query context.
  gnd_pkg::in_beat_t                 query_r;
  logic signed [gnd_pkg::CMP_W-1:0]  lo2_r, hi2_r;
  logic [31:0]                       lat_sq_r, ax_sq_r;
  logic [36:0]                       lim_l, lim_a;

  // Per-reference datapath.
  gnd_pkg::ref_point_t               rd_data;
  logic signed [gnd_pkg::CMP_W-1:0]  rx2;
  logic                              below, above, can_adv, accept, load_ok;
  logic signed [gnd_pkg::ABS_W-1:0]  dx, dy, dz;
  logic [gnd_pkg::ABS_W-1:0]         adx_r, ady_r, adz_r;
  logic [gnd_pkg::SQ_W-1:0]          dx2_r, dy2_r, dz2_r;
  logic                              pass;
  logic [35:0]                       sum_l;
  logic                              div_start, busy_l, busy_a;
  logic [gnd_pkg::QUO_W-1:0]         quo_l, quo_a;
  logic [gnd_pkg::QUO_W:0]           expo;
  logic [ProdW-1:0]                  prod;
  logic [15:0]                       scaled_r;
  logic [31:0]                       recip;
  logic [13:0]                       quot5;
  logic [IW-1:0]                     idx_r;
  logic [gnd_pkg::WEIGHT_W-1:0]      weight;
  logic [gnd_pkg::DENS_W:0]          acc_sum;
  logic [gnd_pkg::DENS_W-1:0]        acc_r;
  logic                              sat_r;
  logic                              mem_we;

  // --------------------------------------------------------------------------
  // APB register file. pready is tied high, so each access completes in its
  // access cycle; address bit 2 selects between the two sigma registers.
  // --------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lat_sigma_r <= gnd_pkg::LATERAL_RESET;
      ax_sigma_r  <= gnd_pkg::AXIAL_RESET;
    end else if (cfg_write) begin
      case (paddr[2])
        gnd_pkg::REG_LATERAL: lat_sigma_r <= pwdata[gnd_pkg::SIGMA_W-1:0];
        gnd_pkg::REG_AXIAL:   ax_sigma_r  <= pwdata[gnd_pkg::SIGMA_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      gnd_pkg::REG_LATERAL: prdata = {16'b0, lat_sigma_r};
      gnd_pkg::REG_AXIAL:   prdata = {16'b0, ax_sigma_r};
      default:              prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Reference store. Loads are written at the accepting edge; the scan reads
  // the entry at the scan pointer, with data available in the next cycle.
  // --------------------------------------------------------------------------
  assign accept  = start && (state_r == gnd_pkg::ST_IDLE);
  assign load_ok = ref_count_r < (AW + 1)'(MaxRefs);
  assign mem_we  = accept && (in_beat.command == gnd_pkg::CMD_LOAD) && load_ok;

  gnd_ref_mem #(.Depth(MaxRefs)) u_mem (
    .clk     (clk),
    .we      (mem_we),
    .waddr   (ref_count_r[AW-1:0]),
    .wdata   ({in_beat.coord_x, in_beat.coord_y, in_beat.coord_z}),
    .raddr   (ptr_r),
    .rdata_r (rd_data)
  );

  // --------------------------------------------------------------------------
  // Window tests on the entry just read. All tests work on doubled values so
  // the 2.5 sigma bounds stay integral.
  // --------------------------------------------------------------------------
  assign rx2     = $signed({{2{rd_data.x[gnd_pkg::COORD_W-1]}}, rd_data.x, 1'b0});
  assign below   = rx2 < lo2_r;
  assign above   = rx2 >= hi2_r;
  assign can_adv = ({1'b0, ptr_r} + 1'b1) < ref_count_r;

  assign dx = $signed({rd_data.x[gnd_pkg::COORD_W-1], rd_data.x})
            - $signed({query_r.coord_x[gnd_pkg::COORD_W-1], query_r.coord_x});
  assign dy = $signed({rd_data.y[gnd_pkg::COORD_W-1], rd_data.y})
            - $signed({query_r.coord_y[gnd_pkg::COORD_W-1], query_r.coord_y});
  assign dz = $signed({rd_data.z[gnd_pkg::COORD_W-1], rd_data.z})
            - $signed({query_r.coord_z[gnd_pkg::COORD_W-1], query_r.coord_z});

  // 25 sigma squared for the y and z tests.
  assign lim_l = {1'b0, lat_sq_r, 4'b0} + {2'b0, lat_sq_r, 3'b0} + {5'b0, lat_sq_r};
  assign lim_a = {1'b0, ax_sq_r, 4'b0} + {2'b0, ax_sq_r, 3'b0} + {5'b0, ax_sq_r};

  assign pass = ({dy2_r, 2'b0} < 52'(lim_l)) && ({dz2_r, 2'b0} < 52'(lim_a));
  // Within the window both squares stay below 6.25 sigma squared, so the
  // lateral sum fits 36 bits and each quotient fits 24 bits.
  assign sum_l = dx2_r[35:0] + dy2_r[35:0];

  // --------------------------------------------------------------------------
  // Exponent: two dividers run side by side, lateral and axial.
  // --------------------------------------------------------------------------
  gnd_div u_div_lat (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({sum_l, 20'b0}),
    .divisor  ({1'b0, lat_sq_r, 1'b0}),
    .busy     (busy_l),
    .quotient (quo_l)
  );

  gnd_div u_div_ax (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({1'b0, dz2_r[34:0], 20'b0}),
    .divisor  ({1'b0, ax_sq_r, 1'b0}),
    .busy     (busy_a),
    .quotient (quo_a)
  );

  // Table index = floor(e * depth / (5 << 21)): shift by 21, then divide by
  // five with the exact 16-bit reciprocal 0xCCCD >> 18, then clip.
  assign expo  = {1'b0, quo_l} + {1'b0, quo_a};
  assign prod  = ProdW'(expo) * ProdW'(ExpDepth);
  assign recip = {16'b0, scaled_r} * 32'h0000CCCD;
  assign quot5 = recip[31:18];

  gnd_weight_rom #(.Depth(ExpDepth)) u_rom (
    .clk      (clk),
    .idx      (idx_r),
    .weight_r (weight)
  );

  assign acc_sum = {1'b0, acc_r} + (gnd_pkg::DENS_W + 1)'(weight);

  // --------------------------------------------------------------------------
  // Sequencer: next state.
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      gnd_pkg::ST_IDLE: begin
        if (accept && (in_beat.command == gnd_pkg::CMD_QUERY)) begin
          state_nxt = gnd_pkg::ST_SETUP;
        end
      end
      gnd_pkg::ST_SETUP: begin
        state_nxt = (ref_count_r == '0) ? gnd_pkg::ST_DONE : gnd_pkg::ST_READ;
      end
      gnd_pkg::ST_READ: state_nxt = gnd_pkg::ST_EVAL;
      gnd_pkg::ST_EVAL: begin
        if (skip_r && can_adv && below) begin
          state_nxt = gnd_pkg::ST_READ;
        end else if (above) begin
          state_nxt = gnd_pkg::ST_DONE;
        end else if (below) begin
          state_nxt = can_adv ? gnd_pkg::ST_READ : gnd_pkg::ST_DONE;
        end else begin
          state_nxt = gnd_pkg::ST_SQUARE;
        end
      end
      gnd_pkg::ST_SQUARE: state_nxt = gnd_pkg::ST_TEST;
      gnd_pkg::ST_TEST: begin
        if (pass) begin
          state_nxt = gnd_pkg::ST_DIVIDE;
        end else begin
          state_nxt = can_adv ? gnd_pkg::ST_READ : gnd_pkg::ST_DONE;
        end
      end
      gnd_pkg::ST_DIVIDE: begin
        if (!busy_l && !busy_a) begin
          state_nxt = gnd_pkg::ST_SCALE;
        end
      end
      gnd_pkg::ST_SCALE:  state_nxt = gnd_pkg::ST_INDEX;
      gnd_pkg::ST_INDEX:  state_nxt = gnd_pkg::ST_LOOKUP;
      gnd_pkg::ST_LOOKUP: state_nxt = gnd_pkg::ST_ACCUM;
      gnd_pkg::ST_ACCUM:  state_nxt = can_adv ? gnd_pkg::ST_READ : gnd_pkg::ST_DONE;
      gnd_pkg::ST_DONE:   state_nxt = gnd_pkg::ST_IDLE;
      default:            state_nxt = gnd_pkg::ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer: outputs.
  // --------------------------------------------------------------------------
  always_comb begin
    busy      = 1'b1;
    out_valid = 1'b0;
    div_start = 1'b0;
    case (state_r)
      gnd_pkg::ST_IDLE: busy      = 1'b0;
      gnd_pkg::ST_TEST: div_start = pass;
      gnd_pkg::ST_DONE: out_valid = 1'b1;
      default: ;
    endcase
  end

  assign out_beat.density   = acc_r;
  assign out_beat.saturated = sat_r;

  // --------------------------------------------------------------------------
  // Control registers.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gnd_pkg::ST_IDLE;
      ref_count_r <= '0;
      win_start_r <= '0;
      ptr_r       <= '0;
      skip_r      <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept && (in_beat.command == gnd_pkg::CMD_CLEAR)) begin
        ref_count_r <= '0;
        win_start_r <= '0;
      end else if (mem_we) begin
        ref_count_r <= ref_count_r + 1'b1;
      end
      if (state_r == gnd_pkg::ST_SETUP) begin
        ptr_r  <= win_start_r;
        skip_r <= 1'b1;
      end else if (state_r == gnd_pkg::ST_EVAL) begin
        // The window start moves forward past references left of the window.
        if (skip_r && can_adv && below) begin
          win_start_r <= AW'({1'b0, ptr_r} + 1'b1);
        end else begin
          skip_r <= 1'b0;
        end
      end else if ((state_r == gnd_pkg::ST_DONE) && query_r.last_query) begin
        win_start_r <= '0;
      end
      if ((state_nxt == gnd_pkg::ST_READ) &&
          ((state_r == gnd_pkg::ST_EVAL) || (state_r == gnd_pkg::ST_TEST) ||
           (state_r == gnd_pkg::ST_ACCUM))) begin
        ptr_r <= ptr_r + 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Datapath registers.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (accept) begin
      query_r <= in_beat;
    end
    case (state_r)
      gnd_pkg::ST_SETUP: begin
        lo2_r <= $signed({{2{query_r.coord_x[gnd_pkg::COORD_W-1]}}, query_r.coord_x, 1'b0})
               - $signed({8'b0, {3'b0, lat_sigma_r} + {1'b0, lat_sigma_r, 2'b0}});
        hi2_r <= $signed({{2{query_r.coord_x[gnd_pkg::COORD_W-1]}}, query_r.coord_x, 1'b0})
               + $signed({8'b0, {3'b0, lat_sigma_r} + {1'b0, lat_sigma_r, 2'b0}});
        lat_sq_r <= {16'b0, lat_sigma_r} * {16'b0, lat_sigma_r};
        ax_sq_r  <= {16'b0, ax_sigma_r} * {16'b0, ax_sigma_r};
        acc_r    <= '0;
        sat_r    <= 1'b0;
      end
      gnd_pkg::ST_EVAL: begin
        adx_r <= dx[gnd_pkg::ABS_W-1] ? gnd_pkg::ABS_W'(-dx) : gnd_pkg::ABS_W'(dx);
        ady_r <= dy[gnd_pkg::ABS_W-1] ? gnd_pkg::ABS_W'(-dy) : gnd_pkg::ABS_W'(dy);
        adz_r <= dz[gnd_pkg::ABS_W-1] ? gnd_pkg::ABS_W'(-dz) : gnd_pkg::ABS_W'(dz);
      end
      gnd_pkg::ST_SQUARE: begin
        dx2_r <= adx_r * adx_r;
        dy2_r <= ady_r * ady_r;
        dz2_r <= adz_r * adz_r;
      end
      gnd_pkg::ST_SCALE: begin
        scaled_r <= 16'(prod[ProdW-1:21]);
      end
      gnd_pkg::ST_INDEX: begin
        idx_r <= (quot5 > 14'(ExpDepth - 1)) ? IW'(ExpDepth - 1) : quot5[IW-1:0];
      end
      gnd_pkg::ST_ACCUM: begin
        if (acc_sum > {1'b0, {gnd_pkg::DENS_W{1'b1}}}) begin
          acc_r <= '1;
          sat_r <= 1'b1;
        end else begin
          acc_r <= acc_sum[gnd_pkg::DENS_W-1:0];
        end
      end
      default: ;
    endcase
  end

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  a_win_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (ref_count_r == '0) || ({1'b0, win_start_r} < ref_count_r))
    else $error("window start passed the reference count");

  a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  a_query_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_beat.command == gnd_pkg::CMD_QUERY)) |=> busy)
    else $error("query accepted without raising busy");

  a_sat_max: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_beat.saturated) |-> (out_beat.density == '1))
    else $error("saturated result below full scale");

endmodule

### bench/tb_gaussian_neighbour_density_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_gaussian_neighbour_density_unit: self-checking regression bench
// Loads sorted and unsorted reference sets, issues queries and compares every
// density beat against an in-bench predictor of the windowed Gaussian sum. It
// covers sigma extremes, a full store with saturation, random passes, idling.
// ----------------------------------------------------------------------------
module tb_gaussian_neighbour_density_unit;

  localparam int NREFS  = 4096;
  localparam int NLUT   = 256;
  localparam logic [1:0] CMD_UNKNOWN = 2'd3;
  localparam logic [2:0] ADDR_LATERAL = 3'd0;
  localparam logic [2:0] ADDR_AXIAL   = 3'd4;
  localparam longint unsigned DENS_MAX = 64'd16777215;

  logic                clk;
  logic                rst_n;
  logic                start;
  logic                busy;
  gnd_pkg::in_beat_t   in_beat;
  logic                out_valid;
  gnd_pkg::out_beat_t  out_beat;
  logic                psel, penable, pwrite;
  logic [2:0]          paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  gaussian_neighbour_density_unit u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_beat(in_beat),
    .out_valid(out_valid), .out_beat(out_beat), .psel(psel), .penable(penable),
    .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
    .pready(pready)
  );

  // Shadow copy of the block's state, kept in step with accepted beats.
  int              shadow_x [NREFS];
  int              shadow_y [NREFS];
  int              shadow_z [NREFS];
  int unsigned     shadow_count;
  int unsigned     shadow_window;
  longint unsigned shadow_lateral;
  longint unsigned shadow_axial;
  logic [15:0]     weight_lut [NLUT];

  gnd_pkg::out_beat_t pending_density [$];
  int        errors;
  int        beats_sent;
  int        queries_sent;
  int        results_seen;
  int        saturated_seen;
  bit        idling_on;
  bit        quiet;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #200ms;
    $display("gaussian_neighbour_density_unit regression: fail");
    $finish;
  end

  // The weight table: a 20-term series gives the ratio of neighbouring entries
  // in Q.32, and each entry is the running product rounded to Q4.12.
  task automatic build_weight_lut();
    longint unsigned step, term, ratio, acc;
    longint          series;
    step   = (64'd10 << 32) / NLUT;
    term   = 64'd1 << 32;
    series = longint'(64'd1 << 32);
    for (int n = 1; n <= 20; n++) begin
      term = ((term * step) >> 32) / longint'(n);
      if (n % 2 == 1) begin
        series -= longint'(term);
      end else begin
        series += longint'(term);
      end
    end
    ratio = longint'(series);
    acc   = 64'd1 << 32;
    for (int k = 0; k < NLUT; k++) begin
      weight_lut[k] = 16'((acc + (64'd1 << 19)) >> 20);
      acc = (acc * ratio) >> 32;
    end
  endtask

  function automatic longint unsigned square_of(longint d);
    longint unsigned a;
    a = (d < 0) ? longint'(-d) : longint'(d);
    return a * a;
  endfunction

  // Applies one accepted beat to the shadow state. A query returns its density.
  function automatic bit apply_command(gnd_pkg::in_beat_t b,
                                       output gnd_pkg::out_beat_t res);
    longint qx, qy, qz, ls, as_, lo2, hi2, rx2;
    longint unsigned lim_l, lim_a, two_l2, two_a2, dx2, dy2, dz2, ex, idx, acc;
    bit sat;
    res = '0;
    qx  = longint'(b.coord_x);
    qy  = longint'(b.coord_y);
    qz  = longint'(b.coord_z);
    case (b.command)
      gnd_pkg::CMD_LOAD: begin
        if (shadow_count < NREFS) begin
          shadow_x[shadow_count] = int'(qx);
          shadow_y[shadow_count] = int'(qy);
          shadow_z[shadow_count] = int'(qz);
          shadow_count++;
        end
        return 1'b0;
      end
      gnd_pkg::CMD_CLEAR: begin
        shadow_count  = 0;
        shadow_window = 0;
        return 1'b0;
      end
      gnd_pkg::CMD_QUERY: ;
      default: return 1'b0;
    endcase
    ls     = longint'(shadow_lateral);
    as_    = longint'(shadow_axial);
    lo2    = 2 * qx - 5 * ls;
    hi2    = 2 * qx + 5 * ls;
    lim_l  = 25 * shadow_lateral * shadow_lateral;
    lim_a  = 25 * shadow_axial * shadow_axial;
    two_l2 = 2 * shadow_lateral * shadow_lateral;
    two_a2 = 2 * shadow_axial * shadow_axial;
    acc    = 0;
    sat    = 1'b0;
    // The window start only moves forward and never passes the last reference.
    while (shadow_window + 1 < shadow_count &&
           2 * longint'(shadow_x[shadow_window]) < lo2) begin
      shadow_window++;
    end
    for (int unsigned i = shadow_window; i < shadow_count; i++) begin
      rx2 = 2 * longint'(shadow_x[i]);
      if (rx2 >= hi2) break;
      if (rx2 < lo2) continue;
      dy2 = square_of(longint'(shadow_y[i]) - qy);
      if (4 * dy2 >= lim_l) continue;
      dz2 = square_of(longint'(shadow_z[i]) - qz);
      if (4 * dz2 >= lim_a) continue;
      if (two_l2 == 0 || two_a2 == 0) continue;
      dx2 = square_of(longint'(shadow_x[i]) - qx);
      ex  = ((dx2 + dy2) << gnd_pkg::FRAC_E) / two_l2
          + (dz2 << gnd_pkg::FRAC_E) / two_a2;
      idx = (ex * NLUT) / (64'd10 << gnd_pkg::FRAC_E);
      if (idx > NLUT - 1) idx = NLUT - 1;
      acc += weight_lut[idx];
      if (acc > DENS_MAX) begin
        acc = DENS_MAX;
        sat = 1'b1;
      end
    end
    if (b.last_query) shadow_window = 0;
    res.density   = gnd_pkg::DENS_W'(acc);
    res.saturated = sat;
    return 1'b1;
  endfunction

  // Result checker: every strobed beat is matched against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      results_seen++;
      if (pending_density.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual density %0d saturated %0b",
                 $time, out_beat.density, out_beat.saturated);
      end else begin
        gnd_pkg::out_beat_t want;
        want = pending_density.pop_front();
        if (want.saturated) saturated_seen++;
        if (out_beat.density !== want.density) begin
          errors++;
          $display("%0t: density mismatch, expected %0d actual %0d",
                   $time, want.density, out_beat.density);
        end
        if (out_beat.saturated !== want.saturated) begin
          errors++;
          $display("%0t: saturated mismatch, expected %0b actual %0b",
                   $time, want.saturated, out_beat.saturated);
        end
      end
    end
  end

  task automatic idle_cycles(int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Sends one beat; returns right after the edge that accepted it.
  task automatic send_beat(gnd_pkg::in_beat_t b);
    gnd_pkg::out_beat_t res;
    if (idling_on && !quiet && $urandom_range(0, 4) == 0) begin
      idle_cycles($urandom_range(1, 11));
    end
    start   <= 1'b1;
    in_beat <= b;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    beats_sent++;
    if (apply_command(b, res)) begin
      pending_density.push_back(res);
      queries_sent++;
    end
  endtask

  // Waits until every expected result is in and the block has gone idle.
  task automatic drain();
    start <= 1'b0;
    do @(posedge clk); while (pending_density.size() != 0 || busy);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_sigma(logic [2:0] addr, logic [15:0] value);
    drain();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= {16'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == ADDR_LATERAL) begin
      shadow_lateral = value;
    end else begin
      shadow_axial = value;
    end
  endtask

  function automatic int clamp24(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return int'(v);
  endfunction

  function automatic gnd_pkg::in_beat_t make_beat(logic [1:0] cmd, longint x,
                                                  longint y, longint z, logic last);
    gnd_pkg::in_beat_t b;
    b.command    = cmd;
    b.coord_x    = gnd_pkg::COORD_W'(clamp24(x));
    b.coord_y    = gnd_pkg::COORD_W'(clamp24(y));
    b.coord_z    = gnd_pkg::COORD_W'(clamp24(z));
    b.last_query = last;
    return b;
  endfunction

  function automatic longint scatter(longint center, longint spread);
    return center + longint'($urandom_range(0, 2 * spread)) - spread;
  endfunction

  // Empty store, clear and unknown command right after reset.
  task automatic test_empty_store();
    send_beat(make_beat(gnd_pkg::CMD_QUERY, 0, 0, 0, 1'b0));
    send_beat(make_beat(CMD_UNKNOWN, 100, 200, 300, 1'b1));
    send_beat(make_beat(gnd_pkg::CMD_CLEAR, 0, 0, 0, 1'b0));
    send_beat(make_beat(gnd_pkg::CMD_QUERY, -8388608, 8388607, -8388608, 1'b1));
  endtask

  // Coordinate extremes, near hits, a miss and the last reference counted.
  task automatic test_directed_points();
    send_beat(make_beat(gnd_pkg::CMD_LOAD, -8388608, -8388608, -8388608, 1'b0));
    send_beat(make_beat(gnd_pkg::CMD_LOAD, -100, 0, 0, 1'b0));
    send_beat(make_beat(gnd_pkg::CMD_LOAD, 0, 0, 0, 1'b0));
    send_beat(make_beat(gnd_pkg::CMD_LOAD, 300, -200, 500, 1'b0));
    send_beat(make_beat(gnd_pkg::CMD_LOAD, 8388607, 8388607, 8388607, 1'b0));
    send_beat(make_beat(gnd_pkg::CMD_QUERY, -8388608, -8388608, -8388608, 1'b0));
    send_beat(make_beat(gnd_pkg::CMD_QUERY, 0, 0, 0, 1'b0));
    send_beat(make_beat(gnd_pkg::CMD_QUERY, 200, 0, 0, 1'b0));
    send_beat(make_beat(gnd_pkg::CMD_QUERY, 8388607, 8388607, 8388607, 1'b1));
    // Unsorted: query behind the window after a pass restart.
    send_beat(make_beat(gnd_pkg::CMD_QUERY, 250, -100, 400, 1'b0));
    send_beat(make_beat(gnd_pkg::CMD_QUERY, -50, 0, 0, 1'b1));
  endtask

  // Narrowest, zero and widest sigma over the same small store.
  task automatic test_sigma_extremes();
    logic [15:0] lat_set [4] = '{16'd1, 16'd0, 16'd65535, 16'd7};
    logic [15:0] ax_set  [4] = '{16'd1, 16'd65535, 16'd65535, 16'd0};
    for (int s = 0; s < 4; s++) begin
      write_sigma(ADDR_LATERAL, lat_set[s]);
      write_sigma(ADDR_AXIAL, ax_set[s]);
      send_beat(make_beat(gnd_pkg::CMD_QUERY, 0, 0, 0, 1'b0));
      send_beat(make_beat(gnd_pkg::CMD_QUERY, 300, -200, 500, 1'b1));
    end
    write_sigma(ADDR_LATERAL, gnd_pkg::LATERAL_RESET);
    write_sigma(ADDR_AXIAL, gnd_pkg::AXIAL_RESET);
  endtask

  // Fills the store with one point plus an extra load that must be dropped;
  // a query on that point sums past the density limit.
  task automatic test_store_full();
    quiet = 1'b1;
    send_beat(make_beat(gnd_pkg::CMD_CLEAR, 0, 0, 0, 1'b0));
    for (int i = 0; i <= NREFS; i++) begin
      send_beat(make_beat(gnd_pkg::CMD_LOAD, 4000, -4000, 123, 1'b0));
    end
    send_beat(make_beat(gnd_pkg::CMD_QUERY, 4000, -4000, 123, 1'b1));
    send_beat(make_beat(gnd_pkg::CMD_CLEAR, 0, 0, 0, 1'b0));
    quiet = 1'b0;
    drain();
  endtask

  // Random passes: sorted reference sets and sorted queries with random content,
  // mixed with unsorted passes, unknown commands and stray pass ends.
  task automatic test_random_passes(int budget);
    int     nrefs, nq, stop_at;
    longint spread, base, x, cy, cz, zspread;
    bit     noisy;
    logic [15:0] pick [6] = '{16'd1, 16'd16, 16'd256, 16'd4096, 16'd65535, 16'd0};
    stop_at = beats_sent + budget;
    while (beats_sent < stop_at) begin
      if ($urandom_range(0, 5) == 0) begin
        write_sigma(ADDR_LATERAL, ($urandom_range(0, 1) != 0) ?
                    pick[$urandom_range(0, 4)] : 16'($urandom_range(1, 65535)));
        write_sigma(ADDR_AXIAL, ($urandom_range(0, 1) != 0) ?
                    pick[$urandom_range(0, 4)] : 16'($urandom_range(1, 65535)));
      end
      idling_on = ($urandom_range(0, 2) != 0);
      quiet     = (beats_sent > stop_at - budget / 6);
      noisy     = ($urandom_range(0, 7) == 0);
      spread    = (shadow_lateral == 0) ? 8 : longint'(shadow_lateral);
      zspread   = (shadow_axial == 0) ? 8 : longint'(shadow_axial);
      if ($urandom_range(0, 3) != 0) begin
        send_beat(make_beat(gnd_pkg::CMD_CLEAR, scatter(0, 8388607),
                            scatter(0, 8388607), scatter(0, 8388607), 1'($urandom)));
      end
      nrefs = $urandom_range(1, 24);
      base  = scatter(0, 8388607 - 80 * spread - 8);
      cy    = scatter(0, 8388607);
      cz    = scatter(0, 8388607);
      x     = base;
      for (int i = 0; i < nrefs; i++) begin
        x = noisy ? scatter(base, 3 * spread) : x + $urandom_range(0, 2 * spread);
        send_beat(make_beat(gnd_pkg::CMD_LOAD, x, scatter(cy, 3 * spread),
                            scatter(cz, 3 * zspread), 1'($urandom)));
      end
      nq = $urandom_range(1, 10);
      x  = base - 4 * spread;
      for (int q = 0; q < nq; q++) begin
        x = noisy ? scatter(base, 6 * spread) : x + $urandom_range(0, 4 * spread);
        if (noisy && $urandom_range(0, 3) == 0) begin
          send_beat(make_beat(CMD_UNKNOWN, x, cy, cz, 1'($urandom)));
        end
        send_beat(make_beat(gnd_pkg::CMD_QUERY, x, scatter(cy, 2 * spread),
                            scatter(cz, 2 * zspread),
                            noisy ? 1'($urandom) : (q == nq - 1)));
      end
    end
  endtask

  initial begin
    errors = 0;  beats_sent = 0;  queries_sent = 0;
    results_seen = 0;  saturated_seen = 0;
    idling_on = 1'b1;  quiet = 1'b0;
    rst_n   <= 1'b0;
    start   <= 1'b0;
    in_beat <= '0;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= '0;
    pwdata  <= '0;
    for (int i = 0; i < NREFS; i++) begin
      shadow_x[i] = 0;  shadow_y[i] = 0;  shadow_z[i] = 0;
    end
    shadow_count   = 0;
    shadow_window  = 0;
    shadow_lateral = gnd_pkg::LATERAL_RESET;
    shadow_axial   = gnd_pkg::AXIAL_RESET;
    build_weight_lut();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_store();
    test_directed_points();
    test_sigma_extremes();
    test_store_full();
    test_random_passes(1750);

    drain();
    repeat (40) @(posedge clk);
    $display("Covered %0d beats, %0d queries, %0d results (%0d saturated),",
             beats_sent, queries_sent, results_seen, saturated_seen);
    $display("sigma extremes, a full store and random sorted and unsorted passes.");
    if (errors == 0 && pending_density.size() == 0) begin
      $display("gaussian_neighbour_density_unit regression: pass");
    end else begin
      $display("gaussian_neighbour_density_unit regression: fail");
    end
    $finish;
  end

endmodule
